// ===== hw/rtl/rse_pkg.sv =====
// Shared types, constants and GF(2^8) arithmetic for the Reed-Solomon parity generator.
package rse_pkg;

  // Low byte of the field's reducing polynomial x^8 + x^4 + x^3 + x^2 + 1.
  localparam logic [7:0] GfPolyLow = 8'h1D;
  // Width and reset value of the parity length register.
  localparam int unsigned EccLenW = 5;
  localparam logic [EccLenW-1:0] EccLenReset = 5'd7;

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_data;
  } data_beat_t;

  // One output beat.
  typedef struct packed {
    logic [7:0] ecc_byte;
    logic       last_ecc;
  } ecc_beat_t;

  // Control shared by every cell of the chain.
  typedef struct packed {
    logic load;      // seed the generator and clear the remainder
    logic gen_step;  // one multiply-by-root step of the generator build
    logic shift;     // a data beat updates the remainder
    logic capture;   // the data beat is last: move the remainder to the output chain
    logic pop;       // an output beat leaves: shift the output chain
  } cell_ctrl_t;

  // Multiply in GF(2^8), one bit of b per step, most significant first.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int bit_idx = 7; bit_idx >= 0; bit_idx--) begin
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? GfPolyLow : 8'h00);
      acc = acc ^ (b[bit_idx] ? a : 8'h00);
    end
    return acc;
  endfunction

  // Multiply by the primitive element 2.
  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GfPolyLow : 8'h00);
  endfunction

endpackage

// ===== hw/rtl/reed_solomon_ecc_encoder.sv =====
// Top level of the systematic Reed-Solomon parity generator over GF(2^8).
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------
//   data in  | data_valid_i / data_stall_o | data_i  (data_byte, last_data)
//   ecc out  | ecc_valid_o / ecc_stall_i   | ecc_o   (ecc_byte, last_ecc)
//   config   | cfg_we_i                    | cfg_wdata_i (ecc_length)
//
// A data beat is taken every cycle unless stalled; each cell updates its remainder byte
// in parallel. A last beat copies the remainder into an output chain that gives L beats,
// one per cycle while the receiver does not stall. A last beat waits until the final beat
// of the previous block leaves, at the latest in the same cycle.
// After reset and after each config write the generator is built: a seed step, then one
// multiply-by-root step per cycle in every cell; data beats are stalled meanwhile.
module reed_solomon_ecc_encoder #(
  parameter int unsigned MAX_ECC_LEN = 30
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              data_valid_i,
  output logic                              data_stall_o,
  input  rse_pkg::data_beat_t               data_i,
  output logic                              ecc_valid_o,
  input  logic                              ecc_stall_i,
  output rse_pkg::ecc_beat_t                ecc_o,
  input  logic                              cfg_we_i,
  input  logic [rse_pkg::EccLenW-1:0]       cfg_wdata_i
);
  import rse_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_ECC_LEN + 1);

  logic [EccLenW-1:0] cfg_len_q;
  logic [LenW-1:0]    eff_len;
  logic               load_q, load_d;
  logic [LenW-1:0]    build_cnt_q, build_cnt_d;
  logic [7:0]         root_q, root_d;
  logic [LenW-1:0]    out_cnt_q, out_cnt_d;
  logic               building;
  logic               in_acc;
  logic               out_pop;
  logic               out_free;
  logic [7:0]         factor;
  logic [7:0]         mul_b;
  cell_ctrl_t         ctrl;

  logic [7:0] rem_w [MAX_ECC_LEN];
  logic [7:0] gen_w [MAX_ECC_LEN];
  logic [7:0] out_w [MAX_ECC_LEN];

  // Effective parity length: zero counts as one, and the length is capped at the chain size.
  always_comb begin
    if (cfg_len_q == '0) begin
      eff_len = LenW'(1);
    end else if (32'(cfg_len_q) > MAX_ECC_LEN) begin
      eff_len = LenW'(MAX_ECC_LEN);
    end else begin
      eff_len = LenW'(cfg_len_q);
    end
  end

  // Handshakes.
  assign building     = load_q || (build_cnt_q != '0);
  assign out_pop      = ecc_valid_o && !ecc_stall_i;
  assign out_free     = (out_cnt_q == '0) || ((out_cnt_q == LenW'(1)) && out_pop);
  assign data_stall_o = building || (data_i.last_data && !out_free);
  assign in_acc       = data_valid_i && !data_stall_o;

  // Shared multiplier operand: the root during the root steps, the feedback factor otherwise.
  assign factor = data_i.data_byte ^ rem_w[0];
  assign mul_b  = (build_cnt_q != '0) ? root_q : factor;

  always_comb begin
    ctrl.load     = load_q;
    ctrl.gen_step = (build_cnt_q != '0);
    ctrl.shift    = in_acc;
    ctrl.capture  = data_i.last_data;
    ctrl.pop      = out_pop;
  end

  // Generator build sequencer: seed, then one root step per parity byte.
  always_comb begin
    load_d      = cfg_we_i;
    build_cnt_d = build_cnt_q;
    root_d      = root_q;
    if (load_q) begin
      build_cnt_d = eff_len;
      root_d      = 8'h01;
    end else if (build_cnt_q != '0) begin
      build_cnt_d = build_cnt_q - LenW'(1);
      root_d      = gf_xtime(root_q);
    end
  end

  // Output beat counter.
  always_comb begin
    out_cnt_d = out_cnt_q;
    if (cfg_we_i) begin
      out_cnt_d = '0;
    end else if (in_acc && data_i.last_data) begin
      out_cnt_d = eff_len;
    end else if (out_pop) begin
      out_cnt_d = out_cnt_q - LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q   <= EccLenReset;
      load_q      <= 1'b1;
      build_cnt_q <= '0;
      out_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_len_q <= cfg_wdata_i;
      end
      load_q      <= load_d;
      build_cnt_q <= build_cnt_d;
      out_cnt_q   <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
  end

  // The chain of cells; the cell past the tail reads zero.
  for (genvar i = 0; i < MAX_ECC_LEN; i++) begin : g_cell
    logic [7:0] rem_nbr;
    logic [7:0] gen_nbr;
    logic [7:0] out_nbr;
    logic       seed;
    if (i + 1 < MAX_ECC_LEN) begin : g_mid
      assign rem_nbr = rem_w[i+1];
      assign gen_nbr = gen_w[i+1];
      assign out_nbr = out_w[i+1];
    end else begin : g_tail
      assign rem_nbr = 8'h00;
      assign gen_nbr = 8'h00;
      assign out_nbr = 8'h00;
    end
    assign seed = (LenW'(i) == (eff_len - LenW'(1)));

    rse_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .seed_i    (seed),
      .mul_b_i   (mul_b),
      .rem_nbr_i (rem_nbr),
      .gen_nbr_i (gen_nbr),
      .out_nbr_i (out_nbr),
      .rem_o     (rem_w[i]),
      .gen_o     (gen_w[i]),
      .out_o     (out_w[i])
    );
  end

  // Output beat.
  assign ecc_valid_o     = (out_cnt_q != '0);
  assign ecc_o.ecc_byte  = out_w[0];
  assign ecc_o.last_ecc  = (out_cnt_q == LenW'(1));

`ifndef NO_ASSERTIONS
  // A config write always starts a generator rebuild.
  a_cfg_rebuild : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> load_q)
    else $error("config write did not start a generator rebuild");

  // The output chain never holds more beats than the parity length.
  a_out_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= eff_len)
    else $error("output beat count exceeds parity length");

  // An accepted last beat is followed by output beats.
  a_last_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && data_i.last_data && !cfg_we_i) |=> ecc_valid_o)
    else $error("last data beat produced no parity beats");

  // The last cell stays zero when it lies past the active length, once the generator is seeded.
  a_tail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!load_q && (eff_len != LenW'(MAX_ECC_LEN))) |->
      (rem_w[MAX_ECC_LEN-1] == 8'h00 && gen_w[MAX_ECC_LEN-1] == 8'h00))
    else $error("unused tail cell is not zero");
`endif

endmodule

// ===== hw/rtl/rse_cell.sv =====
// One cell of the parity chain: a generator coefficient, a remainder byte and an output byte.
module rse_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rse_pkg::cell_ctrl_t ctrl_i,
  input  logic                seed_i,
  input  logic [7:0]          mul_b_i,
  input  logic [7:0]          rem_nbr_i,
  input  logic [7:0]          gen_nbr_i,
  input  logic [7:0]          out_nbr_i,
  output logic [7:0]          rem_o,
  output logic [7:0]          gen_o,
  output logic [7:0]          out_o
);
  import rse_pkg::*;

  logic [7:0] gen_q, gen_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] out_q, out_d;
  logic [7:0] prod;
  logic [7:0] rem_upd;

  // The one multiplier serves both the generator build and the remainder update.
  assign prod    = gf_mul(gen_q, mul_b_i);
  assign rem_upd = rem_nbr_i ^ prod;

  // Generator coefficient.
  always_comb begin
    gen_d = gen_q;
    if (ctrl_i.load) begin
      gen_d = {7'b0, seed_i};
    end else if (ctrl_i.gen_step) begin
      gen_d = prod ^ gen_nbr_i;
    end
  end

  // Remainder: shifts headward plus the scaled coefficient; load or last beat clears it.
  always_comb begin
    rem_d = rem_q;
    if (ctrl_i.load) begin
      rem_d = '0;
    end else if (ctrl_i.shift) begin
      rem_d = ctrl_i.capture ? 8'h00 : rem_upd;
    end
  end

  // Output byte: takes the final remainder, then shifts toward the head per beat.
  always_comb begin
    out_d = out_q;
    if (ctrl_i.shift && ctrl_i.capture) begin
      out_d = rem_upd;
    end else if (ctrl_i.pop) begin
      out_d = out_nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
      rem_q <= '0;
    end else begin
      gen_q <= gen_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rem_o = rem_q;
  assign gen_o = gen_q;
  assign out_o = out_q;

endmodule

// ===== tb/sv/reed_solomon_ecc_encoder_tb.sv =====
// Self-checking testbench for the GF(2^8) Reed-Solomon parity generator.
module reed_solomon_ecc_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rse_pkg::*;

  localparam int MaxEccLen = 30;
  // Cycles to let the block settle before a length write and at the end.
  localparam int SettleCycles = 40;
  localparam int LimitNs = 2_000_000;
  localparam int RandomPhases = 8;
  localparam int ItemsPerPhase = 9;

  // Tracks the parity the block should give and checks every output beat.
  class rs_parity_scoreboard;
    int parity_len;
    logic [7:0] remainder [MaxEccLen];
    logic [7:0] gen_coeff [MaxEccLen];
    ecc_beat_t parity_due[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
      set_length(EccLenReset);
    endfunction

    // Shift-and-add product in GF(2^8), least significant bit of b first.
    function logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] prod;
      logic [7:0] shifted;
      prod = 8'h00;
      shifted = a;
      for (int k = 0; k < 8; k++) begin
        if (b[k]) prod = prod ^ shifted;
        shifted = {shifted[6:0], 1'b0} ^ (shifted[7] ? GfPolyLow : 8'h00);
      end
      return prod;
    endfunction

    // A length write rebuilds the generator and drops any block in progress.
    function void set_length(input logic [EccLenW-1:0] value);
      logic [7:0] poly [MaxEccLen+1];
      logic [7:0] root;
      if (value == 0) parity_len = 1;
      else if (int'(value) > MaxEccLen) parity_len = MaxEccLen;
      else parity_len = int'(value);
      for (int d = 0; d <= MaxEccLen; d++) poly[d] = 8'h00;
      poly[0] = 8'h01;
      root = 8'h01;
      // Multiply the monic polynomial by (x + 2^i), one root at a time.
      for (int i = 0; i < parity_len; i++) begin
        for (int d = i + 1; d > 0; d--) poly[d] = poly[d-1] ^ gf_product(poly[d], root);
        poly[0] = gf_product(poly[0], root);
        root = gf_product(root, 8'h02);
      end
      // Cell j holds the coefficient of x^(L-1-j); the leading one is implied.
      for (int j = 0; j < MaxEccLen; j++) begin
        gen_coeff[j] = (j < parity_len) ? poly[parity_len-1-j] : 8'h00;
        remainder[j] = 8'h00;
      end
    endfunction

    // Runs the division step for one accepted data beat.
    function void note_data_beat(input data_beat_t beat);
      logic [7:0] factor;
      ecc_beat_t parity;
      factor = beat.data_byte ^ remainder[0];
      for (int i = 0; i < parity_len - 1; i++) remainder[i] = remainder[i+1];
      remainder[parity_len-1] = 8'h00;
      for (int i = 0; i < parity_len; i++) begin
        remainder[i] = remainder[i] ^ gf_product(gen_coeff[i], factor);
      end
      if (beat.last_data) begin
        for (int i = 0; i < parity_len; i++) begin
          parity.ecc_byte = remainder[i];
          parity.last_ecc = (i == parity_len - 1);
          parity_due.insert(parity_due.size(), parity);
        end
        for (int i = 0; i < MaxEccLen; i++) remainder[i] = 8'h00;
      end
    endfunction

    // Compares one output beat with the oldest parity still due.
    function void check_parity_beat(input ecc_beat_t got);
      ecc_beat_t want;
      if (parity_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected parity beat: byte %02h last %0b", got.ecc_byte, got.last_ecc);
        end
        return;
      end
      want = parity_due.pop_front();
      if (got.ecc_byte !== want.ecc_byte || got.last_ecc !== want.last_ecc) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Parity beat mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                   want.ecc_byte, want.last_ecc, got.ecc_byte, got.last_ecc);
        end
      end
    endfunction

    function int pending();
      return parity_due.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic data_valid_i = 1'b0;
  logic data_stall_o;
  data_beat_t data_i = '0;
  logic ecc_valid_o;
  logic ecc_stall_i = 1'b0;
  ecc_beat_t ecc_o;
  logic cfg_we_i = 1'b0;
  logic [EccLenW-1:0] cfg_wdata_i = '0;

  int unsigned gap_pct = 0;
  int unsigned ecc_stall_pct = 0;
  rs_parity_scoreboard sb;

  reed_solomon_ecc_encoder #(
    .MAX_ECC_LEN (MaxEccLen)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_valid_i (data_valid_i),
    .data_stall_o (data_stall_o),
    .data_i       (data_i),
    .ecc_valid_o  (ecc_valid_o),
    .ecc_stall_i  (ecc_stall_i),
    .ecc_o        (ecc_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    ecc_stall_i <= ($urandom_range(99) < ecc_stall_pct);
  end

  // Inputs only change at rising edges, so the falling edge sees what the next edge takes.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (data_valid_i && !data_stall_o) sb.note_data_beat(data_i);
      if (ecc_valid_o && !ecc_stall_i) sb.check_parity_beat(ecc_o);
    end
  end

  // Offers one data beat after any random idle cycles and waits until it is taken.
  task automatic send_beat(input logic [7:0] value, input logic is_last);
    data_beat_t beat;
    data_beat_t junk;
    bit taken;
    beat.data_byte = value;
    beat.last_data = is_last;
    while ($urandom_range(99) < gap_pct) begin
      junk.data_byte = 8'($urandom);
      junk.last_data = 1'($urandom);
      data_valid_i <= 1'b0;
      data_i <= junk;
      @(posedge clk_i);
    end
    data_valid_i <= 1'b1;
    data_i <= beat;
    do begin
      @(negedge clk_i);
      taken = !data_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Lowers valid and waits until every parity beat has left and the block is quiet.
  task automatic drain();
    data_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [EccLenW-1:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_length(value);
  endtask

  // One block of random bytes; mostly short, now and then a long one.
  task automatic send_random_block(output int count);
    count = ($urandom_range(7) == 0) ? $urandom_range(20, 10) : $urandom_range(6, 1);
    for (int k = 0; k < count; k++) send_beat(8'($urandom), k == count - 1);
  endtask

  initial begin
    int sent;
    int blk;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset length of seven: extreme bytes, then a block of a single byte.
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h01, 1'b1);
    send_beat(8'hFF, 1'b1);
    // A length of zero acts as one.
    write_length(5'd0);
    send_beat(8'hA5, 1'b0);
    send_beat(8'h5A, 1'b1);
    // A length above the maximum acts as the maximum.
    write_length(5'd31);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    write_length(5'd30);
    send_beat(8'h01, 1'b0);
    send_beat(8'hFE, 1'b0);
    send_beat(8'h7F, 1'b1);
    write_length(5'd1);
    send_beat(8'h00, 1'b1);
    // A length write in the middle of a block abandons it.
    write_length(5'd12);
    send_beat(8'hC3, 1'b0);
    send_beat(8'h3C, 1'b0);
    write_length(5'd7);
    send_beat(8'h55, 1'b0);
    send_beat(8'hAA, 1'b1);

    // Random phases: each one picks a length and a pattern of idling.
    for (int p = 0; p < RandomPhases; p++) begin
      case (p % 4)
        0: begin gap_pct = 0;  ecc_stall_pct = 0;  end
        1: begin gap_pct = 65; ecc_stall_pct = 0;  end
        2: begin gap_pct = 0;  ecc_stall_pct = 65; end
        default: begin gap_pct = 10; ecc_stall_pct = 10; end
      endcase
      if (p % 2 == 1) begin
        write_length(EccLenW'($urandom_range(31)));
      end else begin
        case (p / 2)
          0: write_length(5'd30);
          1: write_length(5'd1);
          2: write_length(5'd16);
          default: write_length(5'd7);
        endcase
      end
      sent = 0;
      while (sent < ItemsPerPhase) begin
        send_random_block(blk);
        sent += blk;
      end
    end

    drain();
    if (sb.mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin
    #(LimitNs);
    $display("Regression FAIL");
    $finish;
  end

endmodule
